// ===== rtl/lcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the cache controller
// control word layout, microprogram table, result kinds and line store bundles
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int AddrW = 16;
  localparam int DataW = 16;

  localparam logic [DataW-1:0] BYTE_MASK = 16'h00FF;
  localparam logic [AddrW-1:0] RESET_TAG = 16'hFFFF;

  // result kinds
  localparam logic [1:0] KIND_DONE      = 2'd0;
  localparam logic [1:0] KIND_MEM_WRITE = 2'd1;
  localparam logic [1:0] KIND_MEM_READ  = 2'd2;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ORGANIZATION = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_POLICY = 2'd1;

  // command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE    = 3'd0;
  localparam step_t ST_LOOKUP  = 3'd1;
  localparam step_t ST_RD_REQ  = 3'd2;
  localparam step_t ST_VICTIM  = 3'd3;
  localparam step_t ST_WR_THRU = 3'd4;
  localparam step_t ST_DONE    = 3'd5;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_RD_REQ,
    EM_VICTIM,
    EM_WR_THRU,
    EM_DONE
  } emit_e;

  typedef enum logic [2:0] {
    GD_NEVER,
    GD_ALWAYS,
    GD_READ_MISS,
    GD_VICTIM_DIRTY,
    GD_WRITE_THRU
  } guard_e;

  typedef enum logic [1:0] {
    JP_NEXT,
    JP_WAIT_START,
    JP_GOTO
  } jump_e;

  typedef struct packed {
    logic   latch;
    logic   lookup;
    logic   commit;
    emit_e  emit;
    guard_e guard;
    jump_e  jump;
    step_t  target;
  } ctrl_t;

  // lookup result of the selected line (hit line or victim)
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] tag;
    logic [DataW-1:0] word;
    logic             bmark;
    logic             dirty;
  } lk_t;

  // line update command
  typedef struct packed {
    logic             en;
    logic             touch;
    logic             wr_tag;
    logic [AddrW-1:0] tag;
    logic             wr_word;
    logic [DataW-1:0] word;
    logic             wr_marks;
    logic             dirty;
    logic             bmark;
  } upd_t;

  // microprogram
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c.latch  = 1'b0;
    c.lookup = 1'b0;
    c.commit = 1'b0;
    c.emit   = EM_NONE;
    c.guard  = GD_NEVER;
    c.jump   = JP_NEXT;
    c.target = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        c.latch = 1'b1;
        c.jump  = JP_WAIT_START;
      end
      ST_LOOKUP: begin
        c.lookup = 1'b1;
      end
      ST_RD_REQ: begin
        c.emit  = EM_RD_REQ;
        c.guard = GD_READ_MISS;
      end
      ST_VICTIM: begin
        c.emit  = EM_VICTIM;
        c.guard = GD_VICTIM_DIRTY;
      end
      ST_WR_THRU: begin
        c.emit  = EM_WR_THRU;
        c.guard = GD_WRITE_THRU;
      end
      ST_DONE: begin
        c.emit   = EM_DONE;
        c.guard  = GD_ALWAYS;
        c.commit = 1'b1;
        c.jump   = JP_GOTO;
        c.target = ST_IDLE;
      end
      default: begin
        c.jump   = JP_GOTO;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/lcc_line_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_line_store: cache lines with tags, words, marks and lru ranks
// parallel tag compare, victim pick and one line update per commit
// ----------------------------------------------------------------------------
module lcc_line_store #(
  parameter int LINES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       org_i,
  input  logic [lcc_pkg::AddrW-1:0]  lk_addr_i,
  input  logic [$clog2(LINES)-1:0]   set_idx_i,
  output lcc_pkg::lk_t               lk_o,
  output logic [$clog2(LINES)-1:0]   lk_line_o,
  input  lcc_pkg::upd_t              upd_i,
  input  logic [$clog2(LINES)-1:0]   upd_line_i
);
  import lcc_pkg::*;

  localparam int IdxW = $clog2(LINES);

  logic [AddrW-1:0] tag_q   [LINES];
  logic [DataW-1:0] word_q  [LINES];
  logic             bmark_q [LINES];
  logic             dirty_q [LINES];
  logic [IdxW-1:0]  rank_q  [LINES];

  logic            any_match;
  logic [IdxW-1:0] match_line;
  logic [IdxW-1:0] oldest_line;
  logic [IdxW-1:0] sel_line;
  logic            sel_hit;
  logic [IdxW-1:0] upd_rank;

  // lowest matching line and lowest line of rank zero
  always_comb begin
    any_match   = 1'b0;
    match_line  = '0;
    oldest_line = '0;
    for (int i = LINES - 1; i >= 0; i--) begin
      if (tag_q[i] == lk_addr_i) begin
        any_match  = 1'b1;
        match_line = IdxW'(i);
      end
      if (rank_q[i] == '0) begin
        oldest_line = IdxW'(i);
      end
    end
    if (org_i) begin
      sel_hit  = any_match;
      sel_line = any_match ? match_line : oldest_line;
    end else begin
      sel_hit  = (tag_q[set_idx_i] == lk_addr_i);
      sel_line = set_idx_i;
    end
  end

  assign lk_o.hit   = sel_hit;
  assign lk_o.tag   = tag_q[sel_line];
  assign lk_o.word  = word_q[sel_line];
  assign lk_o.bmark = bmark_q[sel_line];
  assign lk_o.dirty = dirty_q[sel_line];
  assign lk_line_o  = sel_line;

  assign upd_rank = rank_q[upd_line_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        tag_q[i]   <= RESET_TAG;
        word_q[i]  <= '0;
        bmark_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        rank_q[i]  <= IdxW'(i);
      end
    end else if (upd_i.en) begin
      if (upd_i.touch) begin
        for (int i = 0; i < LINES; i++) begin
          if (IdxW'(i) == upd_line_i) begin
            rank_q[i] <= IdxW'(LINES - 1);
          end else if (rank_q[i] > upd_rank) begin
            rank_q[i] <= rank_q[i] - 1'b1;
          end
        end
      end
      if (upd_i.wr_tag) begin
        tag_q[upd_line_i] <= upd_i.tag;
      end
      if (upd_i.wr_word) begin
        word_q[upd_line_i] <= upd_i.word;
      end
      if (upd_i.wr_marks) begin
        dirty_q[upd_line_i] <= upd_i.dirty;
        bmark_q[upd_line_i] <= upd_i.bmark;
      end
    end
  end

endmodule

// ===== rtl/lcc_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_sequencer: step counter and control store
// walks the microprogram, one control word per cycle
// ----------------------------------------------------------------------------
module lcc_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output lcc_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);
  import lcc_pkg::*;

  step_t step_q;
  step_t step_d;
  ctrl_t ctrl;

  assign ctrl = ucode(step_q);

  always_comb begin
    unique case (ctrl.jump)
      JP_NEXT:       step_d = step_q + 1'b1;
      JP_WAIT_START: step_d = start_i ? step_q + 1'b1 : step_q;
      JP_GOTO:       step_d = ctrl.target;
      default:       step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign busy_o = (step_q != ST_IDLE);

endmodule

// ===== rtl/lru_cache_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_controller: small write-back / write-through cache controller
// fully associative with lru ranks or direct mapped, microcoded control
// ----------------------------------------------------------------------------
// every access runs one accept step plus five microcode steps
// (lookup, read request, victim writeback, writethrough write, completion)
// results are registered and leave in the cycle after their step; completion is last
// next access is accepted in the cycle the completion word is shown
// asynchronous active-low reset: lines hold tag 0xFFFF, ranks by index,
// both configuration registers read 1; results cannot be stalled
module lru_cache_controller #(
  parameter int LINES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic        byte_mode_i,
  input  logic [15:0] memory_word_i,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic        cfg_data_i,
  // result strobe and word
  output logic        result_valid_o,
  output logic [1:0]  kind_o,
  output logic [15:0] out_address_o,
  output logic [15:0] out_data_o,
  output logic        out_byte_mode_o,
  output logic        hit_o,
  output logic        last_o
);
  import lcc_pkg::*;

  localparam int IdxW   = $clog2(LINES);
  localparam int XW     = AddrW - 1;
  // reciprocal for the direct-mapped set index, exact for all XW-bit values
  localparam int ShiftW = XW + IdxW;
  localparam longint unsigned RecipL =
    ((64'd1 << ShiftW) + 64'(LINES) - 64'd1) / 64'(LINES);
  localparam logic [ShiftW:0] Recip = (ShiftW + 1)'(RecipL);
  localparam int ProdW = XW + ShiftW + 1;

  // configuration registers
  logic org_q;
  logic wp_q;

  // sequencer
  ctrl_t ctrl;
  logic  accept;

  // latched access word
  logic             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [DataW-1:0] wdata_q;
  logic             bm_q;
  logic [DataW-1:0] mword_q;
  logic [XW-1:0]    quot_q;

  // direct index arithmetic
  logic [ProdW-1:0] quot_prod;
  logic [XW-1:0]    rem_full;
  logic [IdxW-1:0]  set_idx;

  // lookup
  lk_t             lk;
  logic [IdxW-1:0] lk_line;
  lk_t             lk_q;
  logic [IdxW-1:0] lk_line_q;

  // update and emission
  upd_t             upd;
  logic             miss;
  logic             guard_ok;
  logic [DataW-1:0] wdata_store;

  // result register
  logic             res_valid_q;
  logic [1:0]       res_kind_q;
  logic [AddrW-1:0] res_addr_q;
  logic [DataW-1:0] res_data_q;
  logic             res_bm_q;
  logic             res_hit_q;
  logic             res_last_q;

  // --------------------------------------------------------------------------
  // configuration port, always ready; unknown indexes are dropped
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= 1'b1;
      wp_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ORGANIZATION) begin
        org_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_WRITE_POLICY) begin
        wp_q <= cfg_data_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // step counter and control store
  // --------------------------------------------------------------------------
  lcc_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  assign accept = ctrl.latch && start;

  // --------------------------------------------------------------------------
  // access word capture; the set quotient is taken from the port at accept
  // --------------------------------------------------------------------------
  assign quot_prod = ProdW'(address_i[AddrW-1:1]) * ProdW'(Recip);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      bm_q    <= byte_mode_i;
      mword_q <= memory_word_i;
      quot_q  <= quot_prod[ShiftW +: XW];
    end
  end

  // remainder: (address >> 1) minus quotient times line count
  assign rem_full = addr_q[AddrW-1:1] - XW'(quot_q * XW'(LINES));
  assign set_idx  = rem_full[IdxW-1:0];

  // --------------------------------------------------------------------------
  // line store
  // --------------------------------------------------------------------------
  lcc_line_store #(
    .LINES (LINES)
  ) u_lines (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .org_i      (org_q),
    .lk_addr_i  (addr_q),
    .set_idx_i  (set_idx),
    .lk_o       (lk),
    .lk_line_o  (lk_line),
    .upd_i      (upd),
    .upd_line_i (lk_line_q)
  );

  // selected line snapshot: victim contents survive until commit anyway
  always_ff @(posedge clk_i) begin
    if (ctrl.lookup) begin
      lk_q      <= lk;
      lk_line_q <= lk_line;
    end
  end

  assign miss        = !lk_q.hit;
  assign wdata_store = bm_q ? (wdata_q & BYTE_MASK) : wdata_q;

  // line update at the completion step
  always_comb begin
    upd.en       = ctrl.commit;
    upd.touch    = org_q;
    upd.wr_tag   = miss;
    upd.tag      = addr_q;
    upd.wr_word  = (cmd_q == CMD_WRITE) || miss;
    upd.word     = (cmd_q == CMD_WRITE) ? wdata_store : mword_q;
    upd.wr_marks = wp_q && ((cmd_q == CMD_WRITE) || miss);
    upd.dirty    = (cmd_q == CMD_WRITE);
    upd.bmark    = bm_q;
  end

  // --------------------------------------------------------------------------
  // emission guards
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (ctrl.guard)
      GD_NEVER:        guard_ok = 1'b0;
      GD_ALWAYS:       guard_ok = 1'b1;
      GD_READ_MISS:    guard_ok = (cmd_q == CMD_READ) && miss;
      GD_VICTIM_DIRTY: guard_ok = miss && wp_q && lk_q.dirty;
      GD_WRITE_THRU:   guard_ok = (cmd_q == CMD_WRITE) && !wp_q;
      default:         guard_ok = 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // result register: one word per strobe
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= guard_ok && (ctrl.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= KIND_DONE;
    res_addr_q <= addr_q;
    res_data_q <= '0;
    res_bm_q   <= 1'b0;
    res_hit_q  <= 1'b0;
    res_last_q <= 1'b0;
    unique case (ctrl.emit)
      EM_NONE: begin
      end
      EM_RD_REQ: begin
        res_kind_q <= KIND_MEM_READ;
        res_bm_q   <= bm_q;
      end
      EM_VICTIM: begin
        res_kind_q <= KIND_MEM_WRITE;
        res_addr_q <= lk_q.tag;
        res_data_q <= lk_q.word;
        res_bm_q   <= lk_q.bmark;
      end
      EM_WR_THRU: begin
        // writethrough carries the unmasked data
        res_kind_q <= KIND_MEM_WRITE;
        res_data_q <= wdata_q;
        res_bm_q   <= bm_q;
      end
      EM_DONE: begin
        res_kind_q <= KIND_DONE;
        res_hit_q  <= lk_q.hit;
        res_last_q <= 1'b1;
        if (cmd_q == CMD_READ) begin
          res_data_q <= lk_q.hit ? lk_q.word : mword_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o  = res_valid_q;
  assign kind_o          = res_kind_q;
  assign out_address_o   = res_addr_q;
  assign out_data_o      = res_data_q;
  assign out_byte_mode_o = res_bm_q;
  assign hit_o           = res_hit_q;
  assign last_o          = res_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> kind_o == KIND_DONE)
    else $error("final word of an access is not a completion");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("controller still busy when completion is shown");

  a_idle_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |-> last_o)
    else $error("request word shown while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted access did not start the sequence");

endmodule

// ===== verif/tb_lru_cache_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_cache_controller: self-checking testbench of the cache controller
// a line-store model predicts every result word of each accepted access; a
// directed pass covers reset tags, byte writes and dirty evictions, then
// random accesses run under all four organization / write policy settings
// ----------------------------------------------------------------------------
module tb_lru_cache_controller;
  import lcc_pkg::*;

  localparam int NumLines = 8;
  localparam int RankW    = $clog2(NumLines);

  // register indexes past the two real ones, the block ignores them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
    logic             bm;
    logic [DataW-1:0] mword;
  } access_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic             bm;
    logic             hit;
    logic             last;
  } result_t;

  // clock, reset and every block input start at a known value
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start         = 1'b0;
  logic             cmd_i         = CMD_READ;
  logic [15:0]      address_i     = '0;
  logic [15:0]      write_data_i  = '0;
  logic             byte_mode_i   = 1'b0;
  logic [15:0]      memory_word_i = '0;
  logic             cfg_valid_i   = 1'b0;
  logic [1:0]       cfg_index_i   = CFG_ORGANIZATION;
  logic             cfg_data_i    = 1'b0;

  logic             busy;
  logic             cfg_ready_o;
  logic             result_valid_o;
  logic [1:0]       kind_o;
  logic [15:0]      out_address_o;
  logic [15:0]      out_data_o;
  logic             out_byte_mode_o;
  logic             hit_o;
  logic             last_o;

  lru_cache_controller #(
    .LINES(NumLines)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .byte_mode_i    (byte_mode_i),
    .memory_word_i  (memory_word_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .out_address_o  (out_address_o),
    .out_data_o     (out_data_o),
    .out_byte_mode_o(out_byte_mode_o),
    .hit_o          (hit_o),
    .last_o         (last_o)
  );

  always #2 clk_i = ~clk_i;

  // model copy of the line store and of the two registers
  logic [AddrW-1:0] cache_tag   [NumLines];
  logic [DataW-1:0] cache_word  [NumLines];
  logic             cache_bmark [NumLines];
  logic             cache_dirty [NumLines];
  logic [RankW-1:0] cache_rank  [NumLines];
  logic             cfg_assoc;
  logic             cfg_wback;

  access_t pending_accesses [$];
  result_t expected_results [$];
  access_t live_access = '0;
  int      n_accepted  = 0;
  int      n_mismatch  = 0;

  function automatic void push_result(input logic [1:0] kind, input logic [AddrW-1:0] addr,
                                      input logic [DataW-1:0] data, input logic bm,
                                      input logic hit, input logic last);
    result_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    r.bm   = bm;
    r.hit  = hit;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  // touched line becomes youngest, younger lines slide down one rank
  function automatic void promote_line(input int way);
    logic [RankW-1:0] r;
    r = cache_rank[way];
    for (int i = 0; i < NumLines; i++)
      if (cache_rank[i] > r) cache_rank[i] = cache_rank[i] - 1'b1;
    cache_rank[way] = RankW'(NumLines - 1);
  endfunction

  // lowest-numbered line holding rank 0, line 0 when there is none
  function automatic int oldest_line();
    int way;
    way = 0;
    for (int i = NumLines - 1; i >= 0; i--)
      if (cache_rank[i] == '0) way = i;
    return way;
  endfunction

  // works out every result word of one access and updates the line store
  function automatic void predict_access(input access_t a);
    int               way;
    logic             hit;
    logic [DataW-1:0] rdata;
    way = 0;
    hit = 1'b0;
    if (cfg_assoc) begin
      // descending scan so that the lowest matching line wins
      for (int i = NumLines - 1; i >= 0; i--)
        if (cache_tag[i] == a.addr) begin
          way = i;
          hit = 1'b1;
        end
    end else begin
      way = (int'(a.addr) >> 1) % NumLines;
      hit = (cache_tag[way] == a.addr);
    end

    if (a.cmd == CMD_READ) begin
      if (hit) begin
        rdata = cache_word[way];
        if (cfg_assoc) promote_line(way);
      end else begin
        push_result(KIND_MEM_READ, a.addr, '0, a.bm, 1'b0, 1'b0);
        rdata = a.mword;
        if (cfg_assoc) begin
          way = oldest_line();
          promote_line(way);
        end
        if (cfg_wback) begin
          if (cache_dirty[way]) begin
            push_result(KIND_MEM_WRITE, cache_tag[way], cache_word[way], cache_bmark[way],
                        1'b0, 1'b0);
            cache_dirty[way] = 1'b0;
          end
          cache_bmark[way] = a.bm;
        end
        cache_tag[way]  = a.addr;
        cache_word[way] = a.mword;
      end
      push_result(KIND_DONE, a.addr, rdata, 1'b0, hit, 1'b1);
    end else begin
      if (hit) begin
        if (cfg_assoc) promote_line(way);
      end else begin
        if (cfg_assoc) begin
          way = oldest_line();
          promote_line(way);
        end
        if (cfg_wback && cache_dirty[way])
          push_result(KIND_MEM_WRITE, cache_tag[way], cache_word[way], cache_bmark[way],
                      1'b0, 1'b0);
        cache_tag[way] = a.addr;
      end
      if (cfg_wback) begin
        cache_dirty[way] = 1'b1;
        cache_bmark[way] = a.bm;
      end
      cache_word[way] = a.bm ? (a.wdata & BYTE_MASK) : a.wdata;
      // writethrough sends the raw data with the access size
      if (!cfg_wback) push_result(KIND_MEM_WRITE, a.addr, a.wdata, a.bm, 1'b0, 1'b0);
      push_result(KIND_DONE, a.addr, '0, 1'b0, hit, 1'b1);
    end
  endfunction

  // access driver: holds a word until accepted, then pops the next one or idles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_access(live_access);
        n_accepted++;
      end
      // a word shown while busy stays on the ports unchanged
      if (!(start && busy)) begin
        // accesses 50 to 79 run back to back, the rest idle about 28 percent
        if (pending_accesses.size() != 0 &&
            ((n_accepted >= 50 && n_accepted < 80) || $urandom_range(99, 0) >= 28)) begin
          live_access   = pending_accesses.pop_front();
          start         <= 1'b1;
          cmd_i         <= live_access.cmd;
          address_i     <= live_access.addr;
          write_data_i  <= live_access.wdata;
          byte_mode_i   <= live_access.bm;
          memory_word_i <= live_access.mword;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobed word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && result_valid_o) begin
      got.kind = kind_o;
      got.addr = out_address_o;
      got.data = out_data_o;
      got.bm   = out_byte_mode_o;
      got.hit  = hit_o;
      got.last = last_o;
      if (expected_results.size() == 0) begin
        if (n_mismatch < 10)
          $display("unexpected result word at %0t: kind %0d addr %h data %h bm %b hit %b last %b",
                   $time, got.kind, got.addr, got.data, got.bm, got.hit, got.last);
        n_mismatch++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data ||
            got.bm !== want.bm || got.hit !== want.hit || got.last !== want.last) begin
          if (n_mismatch < 10)
            $display({"result mismatch at %0t (expected/actual): kind %0d/%0d addr %h/%h ",
                      "data %h/%h bm %b/%b hit %b/%b last %b/%b"}, $time,
                     want.kind, got.kind, want.addr, got.addr, want.data, got.data,
                     want.bm, got.bm, want.hit, got.hit, want.last, got.last);
          n_mismatch++;
        end
      end
    end
  end

  // register write, called right after a rising edge while the block is idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_ORGANIZATION) cfg_assoc = val;
    else if (idx == CFG_WRITE_POLICY) cfg_wback = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender pause: everything accepted and answered, then a settle wait
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_accesses.size() != 0 || start || busy || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic void queue_access(input logic cmd, input logic [AddrW-1:0] addr,
                                       input logic [DataW-1:0] wdata, input logic bm,
                                       input logic [DataW-1:0] mword);
    access_t a;
    a.cmd   = cmd;
    a.addr  = addr;
    a.wdata = wdata;
    a.bm    = bm;
    a.mword = mword;
    pending_accesses.push_back(a);
  endfunction

  // mostly a few hot address windows so that hits and conflicts happen
  function automatic access_t random_access();
    access_t     a;
    int unsigned sel;
    sel     = $urandom_range(99, 0);
    a.cmd   = 1'($urandom_range(1, 0));
    a.bm    = 1'($urandom_range(1, 0));
    a.wdata = 16'($urandom);
    a.mword = 16'($urandom);
    if (sel < 10) begin
      a.addr = 16'($urandom);
    end else if (sel < 14) begin
      a.addr = RESET_TAG;
    end else begin
      case ($urandom_range(3, 0))
        0:       a.addr = 16'h0000;
        1:       a.addr = 16'h7FE0;
        2:       a.addr = 16'hFFE0;
        default: a.addr = 16'h5A40;
      endcase
      a.addr = a.addr + 16'($urandom_range(31, 0));
    end
    return a;
  endfunction

  task automatic random_phase(input logic assoc, input logic wback, input int n);
    cfg_write(CFG_ORGANIZATION, assoc);
    cfg_write(CFG_WRITE_POLICY, wback);
    @(negedge clk_i);
    repeat (n) pending_accesses.push_back(random_access());
    wait_idle();
  endtask

  initial begin
    // model reset: tags all ones, ranks by index, both registers set
    for (int i = 0; i < NumLines; i++) begin
      cache_tag[i]   = RESET_TAG;
      cache_word[i]  = '0;
      cache_bmark[i] = 1'b0;
      cache_dirty[i] = 1'b0;
      cache_rank[i]  = RankW'(i);
    end
    cfg_assoc = 1'b1;
    cfg_wback = 1'b1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // associative writeback straight out of reset
    @(negedge clk_i);
    // all-ones address hits line 0 on its reset tag
    queue_access(CMD_READ, RESET_TAG, 16'h0000, 1'b0, 16'h1111);
    queue_access(CMD_WRITE, 16'h0000, 16'hFFFF, 1'b0, 16'h0000);
    // byte write keeps only the low byte
    queue_access(CMD_WRITE, 16'h1234, 16'hABCD, 1'b1, 16'h0000);
    queue_access(CMD_READ, 16'h1234, 16'h0000, 1'b1, 16'hFFFF);
    queue_access(CMD_READ, 16'h2000, 16'h0000, 1'b1, 16'hFFFF);
    // fill the ways so dirty lines get evicted with their byte marks
    for (int k = 0; k < 7; k++)
      queue_access(CMD_WRITE, 16'h0100 + 16'(2 * k), 16'h8000 | 16'(k), k[0], 16'h0000);
    // read miss on a clean victim gives request and completion, no writeback
    queue_access(CMD_READ, 16'h3000, 16'h0000, 1'b0, 16'h5555);
    wait_idle();

    // spare indexes must leave both registers alone
    cfg_write(CFG_SPARE_LO, 1'b0);
    cfg_write(CFG_SPARE_HI, 1'b1);
    cfg_write(CFG_ORGANIZATION, 1'b0);
    @(negedge clk_i);
    // direct mapped writeback, conflicts on line 1
    queue_access(CMD_WRITE, 16'h0002, 16'h0F0F, 1'b0, 16'h0000);
    queue_access(CMD_WRITE, 16'h0012, 16'hF0F0, 1'b1, 16'h0000);
    queue_access(CMD_READ, 16'h0012, 16'h0000, 1'b0, 16'h0000);
    queue_access(CMD_READ, 16'h0022, 16'h0000, 1'b0, 16'hA5A5);
    wait_idle();

    cfg_write(CFG_WRITE_POLICY, 1'b0);
    @(negedge clk_i);
    // writethrough carries the unmasked data, old marks stay untouched
    queue_access(CMD_WRITE, 16'h0022, 16'hFFFF, 1'b1, 16'h0000);
    queue_access(CMD_READ, 16'h0022, 16'h0000, 1'b0, 16'h0000);
    queue_access(CMD_WRITE, 16'hFFFE, 16'h1234, 1'b0, 16'h0000);
    queue_access(CMD_READ, RESET_TAG, 16'h0000, 1'b1, 16'h7E7E);
    wait_idle();

    cfg_write(CFG_ORGANIZATION, 1'b1);
    @(negedge clk_i);
    // associative writethrough
    queue_access(CMD_WRITE, 16'h4444, 16'h0000, 1'b0, 16'h0000);
    queue_access(CMD_READ, 16'h6666, 16'h0000, 1'b0, 16'h0000);
    queue_access(CMD_READ, 16'h0000, 16'h0000, 1'b0, 16'hFFFF);
    wait_idle();

    // random accesses under every setting, each phase drains before the next
    random_phase(1'b1, 1'b1, 15);
    random_phase(1'b0, 1'b1, 15);
    random_phase(1'b0, 1'b0, 15);
    random_phase(1'b1, 1'b0, 15);
    random_phase(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), 15);

    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("lru_cache_controller regression: pass");
    end else begin
      $display("lru_cache_controller regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #200000;
    $display("lru_cache_controller regression: fail");
    $finish;
  end

endmodule

// ===== lru_cache_controller.f =====
rtl/lcc_pkg.sv
rtl/lcc_line_store.sv
rtl/lcc_sequencer.sv
rtl/lru_cache_controller.sv
verif/tb_lru_cache_controller.sv
